/* sv/ukkm_pkg.sv */
// Shared types, constants and the keycode map for the keyboard matrix port.
// Used by ukkm_ctrl, ukkm_datapath and usb_keyboard_to_key_matrix_port.
// No dependencies.
package ukkm_pkg;

   localparam int MATRIX_ROWS_DEFAULT = 11;
   localparam int CSR_INDEX_W = 8;
   localparam int REPORT_W = 64;
   localparam int LENGTH_W = 7;
   localparam int KEY_LANES = 6;
   localparam int FIRST_KEY_BYTE = 2;

   localparam logic [7:0] DATA_PORT_RESET = 8'hA9;
   localparam logic [7:0] SELECT_PORT_RESET = 8'hAA;
   localparam logic [7:0] NO_KEY = 8'hFF;
   localparam logic [LENGTH_W-1:0] REPORT_MIN_LEN = 7'd8;

   // Modifier byte masks (left and right Shift share one matrix bit, as do left and right Ctrl).
   localparam logic [7:0] MOD_SHIFT = 8'h22;
   localparam logic [7:0] MOD_CTRL = 8'h11;
   localparam logic [7:0] MOD_GRAPH = 8'h04;
   localparam logic [7:0] MOD_CODE = 8'h40;
   localparam int MOD_ROW = 6;
   localparam int SHIFT_COL = 0;
   localparam int CTRL_COL = 1;
   localparam int GRAPH_COL = 2;
   localparam int CODE_COL = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_PORT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELECT_PORT = 8'd1;

   typedef enum logic [1:0] {
      KIND_REPORT = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ = 2'd2,
      KIND_UNPLUG = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
   } dp_status_type;

   typedef struct packed {
      logic hit;
      logic [3:0] row;
      logic [2:0] col;
   } key_hit_type;

   function automatic key_hit_type key_at(input logic [3:0] row, input logic [2:0] col);
      key_hit_type res;
      res.hit = 1'b1;
      res.row = row;
      res.col = col;
      return res;
   endfunction

   // Keycode to matrix position. Where the map repeats a code, only the
   // first position is listed, since the first match wins.
   function automatic key_hit_type key_lookup(input logic [7:0] code);
      key_hit_type res;
      case (code)
         8'h27: res = key_at(4'd0, 3'd0);
         8'h1E: res = key_at(4'd0, 3'd1);
         8'h1F: res = key_at(4'd0, 3'd2);
         8'h20: res = key_at(4'd0, 3'd3);
         8'h21: res = key_at(4'd0, 3'd4);
         8'h22: res = key_at(4'd0, 3'd5);
         8'h23: res = key_at(4'd0, 3'd6);
         8'h24: res = key_at(4'd0, 3'd7);
         8'h25: res = key_at(4'd1, 3'd0);
         8'h26: res = key_at(4'd1, 3'd1);
         8'h2D: res = key_at(4'd1, 3'd2);
         8'h2E: res = key_at(4'd1, 3'd3);
         8'h31: res = key_at(4'd1, 3'd4);
         8'h34: res = key_at(4'd1, 3'd5);
         8'h2F: res = key_at(4'd1, 3'd6);
         8'h33: res = key_at(4'd1, 3'd7);
         8'h30: res = key_at(4'd2, 3'd0);
         8'h35: res = key_at(4'd2, 3'd1);
         8'h36: res = key_at(4'd2, 3'd2);
         8'h37: res = key_at(4'd2, 3'd3);
         8'h38: res = key_at(4'd2, 3'd4);
         8'h04: res = key_at(4'd2, 3'd6);
         8'h05: res = key_at(4'd2, 3'd7);
         8'h06: res = key_at(4'd3, 3'd0);
         8'h07: res = key_at(4'd3, 3'd1);
         8'h08: res = key_at(4'd3, 3'd2);
         8'h09: res = key_at(4'd3, 3'd3);
         8'h0A: res = key_at(4'd3, 3'd4);
         8'h0B: res = key_at(4'd3, 3'd5);
         8'h0C: res = key_at(4'd3, 3'd6);
         8'h0D: res = key_at(4'd3, 3'd7);
         8'h0E: res = key_at(4'd4, 3'd0);
         8'h0F: res = key_at(4'd4, 3'd1);
         8'h10: res = key_at(4'd4, 3'd2);
         8'h11: res = key_at(4'd4, 3'd3);
         8'h12: res = key_at(4'd4, 3'd4);
         8'h13: res = key_at(4'd4, 3'd5);
         8'h14: res = key_at(4'd4, 3'd6);
         8'h15: res = key_at(4'd4, 3'd7);
         8'h16: res = key_at(4'd5, 3'd0);
         8'h17: res = key_at(4'd5, 3'd1);
         8'h18: res = key_at(4'd5, 3'd2);
         8'h19: res = key_at(4'd5, 3'd3);
         8'h1A: res = key_at(4'd5, 3'd4);
         8'h1B: res = key_at(4'd5, 3'd5);
         8'h1C: res = key_at(4'd5, 3'd6);
         8'h1D: res = key_at(4'd5, 3'd7);
         8'h39: res = key_at(4'd6, 3'd3);
         8'h3A: res = key_at(4'd6, 3'd5);
         8'h3B: res = key_at(4'd6, 3'd6);
         8'h3C: res = key_at(4'd6, 3'd7);
         8'h3D: res = key_at(4'd7, 3'd0);
         8'h3E: res = key_at(4'd7, 3'd1);
         8'h29: res = key_at(4'd7, 3'd2);
         8'h2B: res = key_at(4'd7, 3'd3);
         8'h48: res = key_at(4'd7, 3'd4);
         8'h2A: res = key_at(4'd7, 3'd5);
         8'h49: res = key_at(4'd7, 3'd6);
         8'h28: res = key_at(4'd7, 3'd7);
         8'h2C: res = key_at(4'd8, 3'd0);
         8'h4A: res = key_at(4'd8, 3'd1);
         8'h4C: res = key_at(4'd8, 3'd3);
         8'h50: res = key_at(4'd8, 3'd4);
         8'h52: res = key_at(4'd8, 3'd5);
         8'h51: res = key_at(4'd8, 3'd6);
         8'h4F: res = key_at(4'd8, 3'd7);
         8'h55: res = key_at(4'd9, 3'd0);
         8'h60: res = key_at(4'd9, 3'd1);
         8'h61: res = key_at(4'd9, 3'd2);
         8'h56: res = key_at(4'd9, 3'd3);
         8'h5D: res = key_at(4'd9, 3'd4);
         8'h63: res = key_at(4'd9, 3'd5);
         8'h5B: res = key_at(4'd9, 3'd6);
         8'h5C: res = key_at(4'd9, 3'd7);
         8'h5E: res = key_at(4'd10, 3'd1);
         8'h5F: res = key_at(4'd10, 3'd2);
         8'h57: res = key_at(4'd10, 3'd3);
         8'h58: res = key_at(4'd10, 3'd4);
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

/* sv/ukkm_ctrl.sv */
// Controller for the keyboard matrix port: captures an item, then executes it.
// Owns the result valid flag. Depends on ukkm_pkg.
module ukkm_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  ukkm_pkg::dp_status_type status,
   output ukkm_pkg::ctrl_cmd_type cmd
);
   import ukkm_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_blocked;

   // A read cannot execute while an earlier result still sits unclaimed.
   assign rsp_blocked = (status.kind == KIND_READ) && rsp_valid_ff && !rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_blocked) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = !rsp_blocked;
            cmd.load_rsp = !rsp_blocked && (status.kind == KIND_READ);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/ukkm_datapath.sv */
// Datapath for the keyboard matrix port: item registers, key matrix,
// row select, port address registers, report decoder and result register.
// Depends on ukkm_pkg.
module ukkm_datapath #(
   parameter int MATRIX_ROWS = ukkm_pkg::MATRIX_ROWS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic [1:0] req_kind,
   input  logic [ukkm_pkg::REPORT_W-1:0] req_report_bytes,
   input  logic [ukkm_pkg::LENGTH_W-1:0] req_report_length,
   input  logic [7:0] req_port_address,
   input  logic [7:0] req_write_data,
   input  logic csr_valid,
   input  logic [ukkm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0] csr_write_data,
   input  ukkm_pkg::ctrl_cmd_type cmd,
   output ukkm_pkg::dp_status_type status,
   output logic rsp_drive_bus,
   output logic [7:0] rsp_read_data
);
   import ukkm_pkg::*;

   localparam int RowIdxW = $clog2(MATRIX_ROWS);

   // Captured item.
   kind_type kind_ff;
   logic [REPORT_W-1:0] bytes_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [7:0] port_ff;
   logic [7:0] wdata_ff;

   logic [7:0] matrix_ff [MATRIX_ROWS];
   logic [7:0] matrix_in [MATRIX_ROWS];
   logic [7:0] report_rows [MATRIX_ROWS];
   logic [3:0] sel_row_ff, sel_row_in;
   logic [7:0] data_port_ff, select_port_ff;
   logic drive_ff;
   logic [7:0] rdata_ff;
   key_hit_type lane_hit [KEY_LANES];
   logic [7:0] mods;
   logic data_match;
   logic [7:0] row_value;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_kind);
         bytes_ff <= req_report_bytes;
         length_ff <= req_report_length;
         port_ff <= req_port_address;
         wdata_ff <= req_write_data;
      end
   end

   assign status.kind = kind_ff;

   // Six keycode decoders against the constant map, all combinational.
   always_comb begin
      for (int k = 0; k < KEY_LANES; k++) begin
         lane_hit[k] = key_lookup(bytes_ff[8*(k+FIRST_KEY_BYTE) +: 8]);
      end
   end

   assign mods = bytes_ff[7:0];

   always_comb begin
      for (int r = 0; r < MATRIX_ROWS; r++) begin
         report_rows[r] = NO_KEY;
         if (r == MOD_ROW) begin
            if ((mods & MOD_SHIFT) != 8'h00) report_rows[r][SHIFT_COL] = 1'b0;
            if ((mods & MOD_CTRL) != 8'h00) report_rows[r][CTRL_COL] = 1'b0;
            if ((mods & MOD_GRAPH) != 8'h00) report_rows[r][GRAPH_COL] = 1'b0;
            if ((mods & MOD_CODE) != 8'h00) report_rows[r][CODE_COL] = 1'b0;
         end
         for (int k = 0; k < KEY_LANES; k++) begin
            if (lane_hit[k].hit && (lane_hit[k].row == 4'(r))) begin
               report_rows[r][lane_hit[k].col] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      matrix_in = matrix_ff;
      sel_row_in = sel_row_ff;
      if (cmd.execute) begin
         case (kind_ff)
            KIND_REPORT: begin
               if (length_ff >= REPORT_MIN_LEN) matrix_in = report_rows;
            end
            KIND_WRITE: begin
               if (port_ff == select_port_ff) sel_row_in = wdata_ff[3:0];
            end
            KIND_UNPLUG: begin
               for (int r = 0; r < MATRIX_ROWS; r++) matrix_in[r] = NO_KEY;
               sel_row_in = '0;
            end
            default: begin
               sel_row_in = sel_row_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MATRIX_ROWS; r++) matrix_ff[r] <= NO_KEY;
         sel_row_ff <= '0;
      end else begin
         matrix_ff <= matrix_in;
         sel_row_ff <= sel_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_port_ff <= DATA_PORT_RESET;
         select_port_ff <= SELECT_PORT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_DATA_PORT) data_port_ff <= csr_write_data;
         if (csr_index == CSR_SELECT_PORT) select_port_ff <= csr_write_data;
      end
   end

   // Rows past the end of the matrix read as no key pressed.
   assign data_match = (port_ff == data_port_ff);
   assign row_value = ({1'b0, sel_row_ff} < 5'(MATRIX_ROWS))
                      ? matrix_ff[sel_row_ff[RowIdxW-1:0]] : NO_KEY;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         drive_ff <= data_match;
         rdata_ff <= data_match ? row_value : NO_KEY;
      end
   end

   assign rsp_drive_bus = drive_ff;
   assign rsp_read_data = rdata_ff;

endmodule

/* sv/usb_keyboard_to_key_matrix_port.sv */
// Top level of the keyboard matrix port.
// Depends on ukkm_pkg, ukkm_ctrl and ukkm_datapath.
//
// Usage:
//   The req_ channel carries one item per beat: a keyboard report, a bus
//   write, a bus read or an unplug event, chosen by req_kind. Only a bus read
//   produces a beat on the rsp_ channel (rsp_drive_bus, rsp_read_data).
//   The always-ready csr_ channel writes the data port address (index 0) and
//   select port address (index 1); writing only while idle is up to the user.
// Flow:
//   An item is captured in the idle state and executed in the execute state;
//   the block takes no new item until the last one has executed. A read
//   result is loaded into the output register when its read executes.
// Reset:
//   All matrix rows read 0xFF, the row select is 0, and the port addresses
//   return to 0xA9 and 0xAA. No result is pending.
// Backpressure:
//   A held result does not stop new items from being taken; only a further
//   read waits in its execute cycle until the output register is free.
module usb_keyboard_to_key_matrix_port #(
   parameter int MATRIX_ROWS = ukkm_pkg::MATRIX_ROWS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_kind,
   input  logic [ukkm_pkg::REPORT_W-1:0] req_report_bytes,
   input  logic [ukkm_pkg::LENGTH_W-1:0] req_report_length,
   input  logic [7:0] req_port_address,
   input  logic [7:0] req_write_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_drive_bus,
   output logic [7:0] rsp_read_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [ukkm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0] csr_write_data
);
   import ukkm_pkg::*;

   ctrl_cmd_type cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   ukkm_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status(status),
      .cmd(cmd)
   );

   ukkm_datapath #(
      .MATRIX_ROWS(MATRIX_ROWS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_kind(req_kind),
      .req_report_bytes(req_report_bytes),
      .req_report_length(req_report_length),
      .req_port_address(req_port_address),
      .req_write_data(req_write_data),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cmd(cmd),
      .status(status),
      .rsp_drive_bus(rsp_drive_bus),
      .rsp_read_data(rsp_read_data)
   );

endmodule
